>>> src/fwpid_pkg.sv
// Shared constants, register codes and control types of the four-wheel PID controller.
package fwpid_pkg;

    localparam int WHEELS     = 4;
    localparam int FRAC_BITS  = 8;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 13;
    localparam int ERR_W      = IN_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int INTEG_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int OFS_W      = 24;
    localparam int DIR_W      = WHEELS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SUM_W      = 53;
    localparam int PIPE_DEPTH = 4;
    localparam int OUT_LIMIT  = 2048;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd7680;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd51;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd7680;
    localparam logic [GAIN_W-1:0] FF_SLOPE_RST   = 16'd7749;
    localparam logic [OFS_W-1:0]  FF_OFFSET_RST  = 24'd28326;
    localparam logic [DIR_W-1:0]  DIR_MASK_RST   = 4'hF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_FF_SLOPE       = 3'd3,
        REG_FF_OFFSET      = 3'd4,
        REG_DIRECTION_MASK = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]        prop_gain;
        logic [GAIN_W-1:0]        integ_gain;
        logic [GAIN_W-1:0]        deriv_gain;
        logic [GAIN_W-1:0]        ff_slope;
        logic signed [OFS_W-1:0]  ff_offset;
    } t_gains;

    // One load strobe per pipeline stage, stage 0 first.
    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
    } t_pipe_ctl;

endpackage

>>> src/fwpid_lane.sv
// One wheel lane: error and integral update, gain products, sum, direction, clamp, truncate.
module fwpid_lane (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  fwpid_pkg::t_pipe_ctl                    i_ctl,
    input  fwpid_pkg::t_gains                       i_gains,
    input  logic                                    i_dir,
    input  logic signed [fwpid_pkg::IN_W-1:0]       i_target,
    input  logic signed [fwpid_pkg::IN_W-1:0]       i_speed,
    output logic signed [fwpid_pkg::OUT_W-1:0]      o_power
);
    import fwpid_pkg::*;

    localparam int PFF_W = GAIN_W + 1 + IN_W;
    localparam int PP_W  = GAIN_W + 1 + ERR_W;
    localparam int PI_W  = GAIN_W + 1 + INTEG_W;
    localparam int PD_W  = GAIN_W + 1 + DIFF_W;
    localparam int SHIFT = 2 * FRAC_BITS;
    localparam logic signed [SUM_W-1:0] LIMIT = SUM_W'(OUT_LIMIT) << SHIFT;
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // Stage 0: wheel state and the values the products need
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [ERR_W-1:0]    r_last_err;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [IN_W-1:0]     r_tgt;

    logic signed [ERR_W-1:0]    w_err;
    logic signed [INTEG_W:0]    w_integ_sum;
    logic signed [INTEG_W-1:0]  n_integ;
    logic signed [DIFF_W-1:0]   w_diff;

    always_comb begin
        w_err       = ERR_W'(i_target) - ERR_W'(i_speed);
        w_integ_sum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(w_err);
        if (w_integ_sum[INTEG_W] != w_integ_sum[INTEG_W-1]) begin
            n_integ = w_integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            n_integ = w_integ_sum[INTEG_W-1:0];
        end
        w_diff = DIFF_W'(w_err) - DIFF_W'(r_last_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
        end else if (i_ctl.load[0]) begin
            r_integ    <= n_integ;
            r_last_err <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_err  <= w_err;
            r_diff <= w_diff;
            r_tgt  <= i_target;
        end
    end

    // Stage 1: one multiplier per term
    logic signed [PFF_W-1:0] r_pff;
    logic signed [PP_W-1:0]  r_pp;
    logic signed [PI_W-1:0]  r_pi;
    logic signed [PD_W-1:0]  r_pd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_pff <= PFF_W'($signed({1'b0, i_gains.ff_slope})) * PFF_W'(r_tgt);
            r_pp  <= PP_W'($signed({1'b0, i_gains.prop_gain})) * PP_W'(r_err);
            r_pi  <= PI_W'($signed({1'b0, i_gains.integ_gain})) * PI_W'(r_integ);
            r_pd  <= PD_W'($signed({1'b0, i_gains.deriv_gain})) * PD_W'(r_diff);
        end
    end

    // Stage 2: exact sum in Q.16
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] w_ofs;

    assign w_ofs = SUM_W'(i_gains.ff_offset) <<< FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_sum <= SUM_W'(r_pff) + SUM_W'(r_pp) + SUM_W'(r_pi) + SUM_W'(r_pd) + w_ofs;
        end
    end

    // Stage 3: direction, clamp, drop fraction toward zero
    logic signed [SUM_W-1:0] w_dir_sum;
    logic signed [SUM_W-1:0] w_shift;
    logic signed [OUT_W-1:0] n_power;
    logic                    w_round_up;

    always_comb begin
        w_dir_sum  = i_dir ? r_sum : -r_sum;
        w_shift    = w_dir_sum >>> SHIFT;
        w_round_up = w_dir_sum[SUM_W-1] && (|w_dir_sum[SHIFT-1:0]);
        if (w_dir_sum > LIMIT) begin
            n_power = OUT_W'(OUT_LIMIT);
        end else if (w_dir_sum < -LIMIT) begin
            n_power = -OUT_W'(OUT_LIMIT);
        end else begin
            n_power = OUT_W'(w_shift) + OUT_W'(w_round_up);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            o_power <= n_power;
        end
    end

endmodule

>>> src/fwpid_ctrl.sv
// Pipeline flow control: stage valid bits, stall chain and per-stage load strobes.
module fwpid_ctrl (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic                                    i_stall,
    output logic                                    o_stall,
    output logic                                    o_valid,
    output fwpid_pkg::t_pipe_ctl                    o_ctl,
    output logic [fwpid_pkg::PIPE_DEPTH-1:0]        o_busy
);
    import fwpid_pkg::*;

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic [PIPE_DEPTH:0]   w_ready;

    always_comb begin
        w_ready[PIPE_DEPTH] = !i_stall;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            w_ready[k] = !r_vld[k] || w_ready[k+1];
        end
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (k == 0) begin
                o_ctl.load[k] = i_valid && w_ready[k];
                n_vld[k]      = w_ready[k] ? i_valid : r_vld[k];
            end else begin
                o_ctl.load[k] = r_vld[k-1] && w_ready[k];
                n_vld[k]      = w_ready[k] ? r_vld[k-1] : r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !w_ready[0];
    assign o_valid = r_vld[PIPE_DEPTH-1];
    assign o_busy  = r_vld;

endmodule

>>> src/four_wheel_pid_with_feedforward_top.sv
// Top level of the four-wheel PID speed controller with feedforward.
// Each transaction on the input channel is one control tick: a signed Q8.8 target
// and measured speed for each of four wheels. Per wheel the block forms
// error = target - speed, adds it to a saturating 32-bit integral, and computes
// ff_slope*target + ff_offset + prop_gain*error + integ_gain*integral
// + deriv_gain*(error - previous error) exactly in Q.16. The sign flips where the
// direction_mask bit is clear; the value is clamped to +-2048 and its fraction
// dropped toward zero. One output transaction carries all four powers.
// Four identical lanes run side by side, each a four-stage pipeline (state update,
// gain products, sum, clamp/truncate) ending in the output register; the lanes
// share one flow controller so their results leave together. Throughput is one
// tick per cycle while the sink does not stall. Integral and previous-error state
// update in the accept cycle, so back-to-back ticks see the right history. The user
// must write gains through the register port only while no tick is in flight; the
// block itself does not enforce it. Integral and previous error clear on reset.
module four_wheel_pid_with_feedforward_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [fwpid_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [fwpid_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [fwpid_pkg::IN_W-1:0]       i_target_0,
    input  logic signed [fwpid_pkg::IN_W-1:0]       i_target_1,
    input  logic signed [fwpid_pkg::IN_W-1:0]       i_target_2,
    input  logic signed [fwpid_pkg::IN_W-1:0]       i_target_3,
    input  logic signed [fwpid_pkg::IN_W-1:0]       i_speed_0,
    input  logic signed [fwpid_pkg::IN_W-1:0]       i_speed_1,
    input  logic signed [fwpid_pkg::IN_W-1:0]       i_speed_2,
    input  logic signed [fwpid_pkg::IN_W-1:0]       i_speed_3,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [fwpid_pkg::OUT_W-1:0]      o_power_0,
    output logic signed [fwpid_pkg::OUT_W-1:0]      o_power_1,
    output logic signed [fwpid_pkg::OUT_W-1:0]      o_power_2,
    output logic signed [fwpid_pkg::OUT_W-1:0]      o_power_3
);
    import fwpid_pkg::*;

    // Configuration registers
    t_gains           r_gains;
    logic [DIR_W-1:0] r_dir_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop_gain  <= PROP_GAIN_RST;
            r_gains.integ_gain <= INTEG_GAIN_RST;
            r_gains.deriv_gain <= DERIV_GAIN_RST;
            r_gains.ff_slope   <= FF_SLOPE_RST;
            r_gains.ff_offset  <= FF_OFFSET_RST;
            r_dir_mask         <= DIR_MASK_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_PROP_GAIN:      r_gains.prop_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:     r_gains.integ_gain <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:     r_gains.deriv_gain <= i_cfg_data[GAIN_W-1:0];
                REG_FF_SLOPE:       r_gains.ff_slope   <= i_cfg_data[GAIN_W-1:0];
                REG_FF_OFFSET:      r_gains.ff_offset  <= i_cfg_data[OFS_W-1:0];
                REG_DIRECTION_MASK: r_dir_mask         <= i_cfg_data[DIR_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Flow control shared by all lanes
    t_pipe_ctl             w_ctl;
    logic [PIPE_DEPTH-1:0] w_busy;

    fwpid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_ctl   (w_ctl),
        .o_busy  (w_busy)
    );

    // Gather wheel inputs into lane order
    logic signed [IN_W-1:0]  w_target [WHEELS];
    logic signed [IN_W-1:0]  w_speed  [WHEELS];
    logic signed [OUT_W-1:0] w_power  [WHEELS];

    assign w_target[0] = i_target_0;
    assign w_target[1] = i_target_1;
    assign w_target[2] = i_target_2;
    assign w_target[3] = i_target_3;
    assign w_speed[0]  = i_speed_0;
    assign w_speed[1]  = i_speed_1;
    assign w_speed[2]  = i_speed_2;
    assign w_speed[3]  = i_speed_3;

    for (genvar g = 0; g < WHEELS; g++) begin : g_lane
        fwpid_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_gains  (r_gains),
            .i_dir    (r_dir_mask[g]),
            .i_target (w_target[g]),
            .i_speed  (w_speed[g]),
            .o_power  (w_power[g])
        );
    end

    // Merge lane results onto the output transaction
    assign o_power_0 = w_power[0];
    assign o_power_1 = w_power[1];
    assign o_power_2 = w_power[2];
    assign o_power_3 = w_power[3];

`ifndef SYNTHESIS
    // Hold off upstream only when the whole pipe is full and the sink stalls.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (i_stall && (&w_busy)))
        else $error("input stalled while pipeline had room");

    // A tick accepted with an idle downstream emerges after the pipeline latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> o_valid)
        else $error("accepted tick did not reach the output in time");

    // Delivered powers of wheels 0 and 3 stay inside the clamp range.
    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_power_0 <= 13'sd2048 && o_power_0 >= -13'sd2048 &&
                     o_power_3 <= 13'sd2048 && o_power_3 >= -13'sd2048))
        else $error("output power outside clamp range");

    // Nothing leaves right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule
